// File: rtl/core/sst_pkg.sv
// sst_pkg: shared types and constants for the small set table
// holds the transfer payload structs, operation codes, fsm states and cell controls
// no dependencies
`default_nettype none

package sst_pkg;

   // fixed field widths of the transfer payloads and the capacity register
   localparam int ITEM_BITS  = 32;
   localparam int COUNT_BITS = 5;
   localparam int CAP_BITS   = 5;

   // capacity register
   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;
   localparam int                  CSR_ADDR_BITS = 3;
   localparam logic                REG_CAPACITY  = 1'b0;

   // operation codes
   typedef enum logic [1:0] {
      FUNC_LOOKUP = 2'd0,
      FUNC_ADD    = 2'd1,
      FUNC_ERASE  = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   // input transfer payload
   typedef struct packed {
      func_type               func;
      logic [ITEM_BITS-1:0]   item;
   } req_type;

   // result transfer payload
   typedef struct packed {
      logic                   ok;
      logic [COUNT_BITS-1:0]  count;
   } rsp_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_CMP  = 2'd1,
      ST_UPD  = 2'd2
   } state_type;

   // controls broadcast to every cell of the row
   typedef struct packed {
      logic cmp_en;
      logic erase_en;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// File: rtl/core/small_set_table.sv
// small_set_table: set of distinct keys in a row of compare cells; lookup, add, erase, clear
// after the input transfer the item passes the compare stage, then the result register loads in the update stage
// a new item is taken only while idle or as the previous one commits from the update stage
// a waiting result holds the update stage, and the input stalls, until the result is taken
// reset: count 0, capacity 16; keys are not cleared, so no clearing pass is needed
// depends on sst_pkg and sst_cell
`default_nettype none

module small_set_table #(
   parameter int DEPTH    = 16,
   parameter int KEY_BITS = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire sst_pkg::req_type                    req_data,
   // result channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output sst_pkg::rsp_type                         rsp_data,
   // configuration port
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [sst_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [31:0]                         csr_pwdata,
   output logic      [31:0]                         csr_prdata,
   output logic                                     csr_pready
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > sst_pkg::CAP_BITS) ? CNT_W : sst_pkg::CAP_BITS;
   localparam int IN_W  = (KEY_BITS < sst_pkg::ITEM_BITS) ? KEY_BITS : sst_pkg::ITEM_BITS;

   sst_pkg::state_type                state_ff, state_in;
   sst_pkg::func_type                 func_ff, func_in;
   logic [KEY_BITS-1:0]               key_ff, key_in;
   logic [CNT_W-1:0]                  fill_ff, fill_in;
   logic [sst_pkg::CAP_BITS-1:0]      cap_ff, cap_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   sst_pkg::rsp_type                  rsp_ff, rsp_in;

   logic                              accept;
   logic                              out_free;
   logic                              commit;
   logic                              found;
   logic                              has_room;
   logic                              do_load;
   logic                              ok;
   logic [CMP_W-1:0]                  fill_ext;
   logic [CMP_W-1:0]                  fill_next_ext;
   sst_pkg::cell_ctrl_type            ctrl;

   logic [DEPTH-1:0]                  held;
   logic [DEPTH-1:0]                  load_vec;
   logic [DEPTH-1:0]                  match_vec;
   logic [KEY_BITS-1:0]               entry_w [DEPTH];
   logic [DEPTH:0]                    shift_w;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_prdata = 32'(cap_ff);

   always_comb begin
      cap_in = cap_ff;
      if (csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == sst_pkg::REG_CAPACITY)) begin
         cap_in = csr_pwdata[sst_pkg::CAP_BITS-1:0];
      end
   end

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign commit    = (state_ff == sst_pkg::ST_UPD) && out_free;
   assign req_stall = !((state_ff == sst_pkg::ST_IDLE) || commit);
   assign accept    = req_valid && !req_stall;

   // capture the operation
   always_comb begin
      func_in = func_ff;
      key_in  = key_ff;
      if (accept) begin
         func_in = req_data.func;
         key_in  = KEY_BITS'(req_data.item[IN_W-1:0]);
      end
   end

   // per-slot occupancy and append select
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         held[i]     = CNT_W'(i) < fill_ff;
         load_vec[i] = do_load && (CNT_W'(i) == fill_ff);
      end
   end

   // decision of the update stage
   assign found    = |match_vec;
   assign fill_ext = CMP_W'(fill_ff);
   assign has_room = (fill_ext < CMP_W'(cap_ff)) && (fill_ext < CMP_W'(DEPTH));

   always_comb begin
      ctrl.cmp_en   = (state_ff == sst_pkg::ST_CMP);
      ctrl.erase_en = 1'b0;
      do_load       = 1'b0;
      ok            = 1'b1;
      fill_in       = fill_ff;
      unique case (func_ff)
         sst_pkg::FUNC_LOOKUP: begin
            ok = found;
         end
         sst_pkg::FUNC_ADD: begin
            if (!found) begin
               ok = has_room;
               if (has_room && commit) begin
                  do_load = 1'b1;
                  fill_in = fill_ff + CNT_W'(1);
               end
            end
         end
         sst_pkg::FUNC_ERASE: begin
            if (found && commit) begin
               ctrl.erase_en = 1'b1;
               fill_in       = fill_ff - CNT_W'(1);
            end
         end
         sst_pkg::FUNC_CLEAR: begin
            if (commit) begin
               fill_in = '0;
            end
         end
         default: begin
            ok = 1'b1;
         end
      endcase
   end

   // result register
   assign fill_next_ext = CMP_W'(fill_in);

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (commit) begin
         rsp_in.ok    = ok;
         rsp_in.count = fill_next_ext[sst_pkg::COUNT_BITS-1:0];
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sst_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = sst_pkg::ST_CMP;
            end
         end
         sst_pkg::ST_CMP: begin
            state_in = sst_pkg::ST_UPD;
         end
         sst_pkg::ST_UPD: begin
            if (commit) begin
               state_in = accept ? sst_pkg::ST_CMP : sst_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sst_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sst_pkg::ST_IDLE;
         fill_ff      <= '0;
         cap_ff       <= sst_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      key_ff  <= key_in;
      rsp_ff  <= rsp_in;
   end

   // row of cells; the erase shift flag ripples from the head toward the tail
   assign shift_w[0] = 1'b0;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [KEY_BITS-1:0] upper;
      if (g == DEPTH - 1) begin : g_tail
         assign upper = entry_w[g];
      end else begin : g_body
         assign upper = entry_w[g+1];
      end

      sst_cell #(
         .KEY_BITS (KEY_BITS)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .held       (held[g]),
         .load       (load_vec[g]),
         .key        (key_ff),
         .next_entry (upper),
         .shift_in   (shift_w[g]),
         .entry      (entry_w[g]),
         .shift_out  (shift_w[g+1]),
         .match      (match_vec[g])
      );
   end

   // keys are distinct, so at most one slot matches
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sst_pkg::ST_UPD) |-> $onehot0(match_vec))
      else $error("more than one slot matched the key");

   // a match must carry the shift flag to the end of the row
   a_shift_reaches_tail: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == sst_pkg::ST_UPD) && found) |-> shift_w[DEPTH])
      else $error("erase shift flag lost in the row");

   // occupancy stays within the table
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ext <= CMP_W'(DEPTH))
      else $error("fill exceeds table depth");

   // an append only happens below the capacity
   a_append_room: assert property (@(posedge clock) disable iff (reset)
      do_load |-> (fill_ext < CMP_W'(cap_ff)))
      else $error("append beyond capacity");

   // a waiting result always reports the current count
   a_count_current: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.count == fill_ext[sst_pkg::COUNT_BITS-1:0]))
      else $error("result count differs from held count");

   // clear empties the set
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      (commit && (func_ff == sst_pkg::FUNC_CLEAR)) |=> (fill_ff == '0))
      else $error("clear left keys in the set");

endmodule

`default_nettype wire

// File: rtl/core/sst_cell.sv
// sst_cell: one slot of the set table row
// holds one key, compares it against the broadcast key, and shifts toward the head on erase
// depends on sst_pkg
`default_nettype none

module sst_cell #(
   parameter int KEY_BITS = 32
) (
   input  wire logic                   clock,
   input  wire sst_pkg::cell_ctrl_type ctrl,
   input  wire logic                   held,
   input  wire logic                   load,
   input  wire logic [KEY_BITS-1:0]    key,
   input  wire logic [KEY_BITS-1:0]    next_entry,
   input  wire logic                   shift_in,
   output logic      [KEY_BITS-1:0]    entry,
   output logic                        shift_out,
   output logic                        match
);

   logic [KEY_BITS-1:0] entry_ff;
   logic [KEY_BITS-1:0] entry_in;
   logic                match_ff;
   logic                match_in;
   logic                shift;

   // a slot at or above the erased key takes its upper neighbor's key
   assign shift     = shift_in | match_ff;
   assign shift_out = shift;

   // compare only slots that hold a key
   always_comb begin
      match_in = match_ff;
      if (ctrl.cmp_en) begin
         match_in = held && (entry_ff == key);
      end
   end

   // slot write: append load or erase shift
   always_comb begin
      priority if (load) begin
         entry_in = key;
      end else if (ctrl.erase_en && shift) begin
         entry_in = next_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

`default_nettype wire

// File: tb/tb.sv
// tb: self-checking bench for small_set_table, a set of distinct keys with lookup/add/erase/clear
// directed table then random phases across capacity settings, checked against fixed expectations or a set predictor
// depends on sst_pkg and the small_set_table rtl
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH   = 16;
   localparam int PHASES        = 10;
   localparam int PHASE_ITEMS   = 110;
   localparam int POOL_SIZE     = 20;
   localparam int SETTLE_CYCLES = 6;
   localparam int HOLD_CYCLES   = 120;
   localparam int CYCLE_LIMIT   = 600000;

   localparam int ADDR_BITS = sst_pkg::CSR_ADDR_BITS;
   localparam int KEY_W     = sst_pkg::ITEM_BITS;
   localparam int CAP_W     = sst_pkg::CAP_BITS;
   localparam int CNT_W     = sst_pkg::COUNT_BITS;

   // byte addresses of the config registers
   localparam logic [ADDR_BITS-1:0] ADDR_CAPACITY =
      ADDR_BITS'(4 * int'(sst_pkg::REG_CAPACITY));
   localparam logic [ADDR_BITS-1:0] ADDR_UNUSED   = ADDR_BITS'(4);

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   sst_pkg::req_type         req_data;
   logic                     rsp_valid;
   logic                     rsp_stall;
   sst_pkg::rsp_type         rsp_data;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [ADDR_BITS-1:0]     csr_paddr;
   logic [31:0]              csr_pwdata;
   logic [31:0]              csr_prdata;
   logic                     csr_pready;

   // one line of the directed plan: either a register write or an operation
   typedef struct {
      bit                       is_csr;
      logic [ADDR_BITS-1:0]     addr;
      logic [31:0]              wdata;
      sst_pkg::req_type         op;
      bit                       typed;
      sst_pkg::rsp_type         want;
   } plan_row_type;

   // predicted set contents
   logic [KEY_W-1:0]     set_keys [TABLE_DEPTH];
   int                   set_fill;
   logic [CAP_W-1:0]     cap_reg;

   sst_pkg::rsp_type     due_results[$];
   sst_pkg::rsp_type     head_result;
   plan_row_type         plan[$];
   logic [KEY_W-1:0]     key_pool [POOL_SIZE];
   logic [CAP_W-1:0]     cap_plan [PHASES] = '{5'd31, 5'd16, 5'd5, 5'd0, 5'd1,
                                              5'd20, 5'd3, 5'd31, 5'd8, 5'd16};
   int                   fault_count;
   int                   cycle_count;
   bit                   quiet_phase;
   bit                   hold_request;
   bit                   hold_taken;
   int                   stall_left;

   small_set_table #(
      .DEPTH    (TABLE_DEPTH),
      .KEY_BITS (KEY_W)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // set behavior: one operation in, one result out
   function automatic sst_pkg::rsp_type set_apply(sst_pkg::req_type r);
      int               i;
      int               slot;
      int               lim;
      sst_pkg::rsp_type res;
      slot = TABLE_DEPTH;
      for (i = 0; i < set_fill; i++) begin
         if (slot == TABLE_DEPTH && set_keys[i] == r.item) slot = i;
      end
      lim = (cap_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(cap_reg);
      res.ok = 1'b1;
      case (r.func)
         sst_pkg::FUNC_LOOKUP: res.ok = (slot < TABLE_DEPTH);
         sst_pkg::FUNC_ADD: begin
            if (slot == TABLE_DEPTH) begin
               if (set_fill >= lim) begin
                  res.ok = 1'b0;
               end else begin
                  set_keys[set_fill] = r.item;
                  set_fill++;
               end
            end
         end
         sst_pkg::FUNC_ERASE: begin
            // last entry moves into the freed slot
            if (slot < TABLE_DEPTH) begin
               set_keys[slot] = set_keys[set_fill-1];
               set_fill--;
            end
         end
         sst_pkg::FUNC_CLEAR: set_fill = 0;
      endcase
      res.count = CNT_W'(set_fill);
      return res;
   endfunction

   function automatic plan_row_type check_row(sst_pkg::func_type f, logic [KEY_W-1:0] k,
                                              logic ok, logic [CNT_W-1:0] cnt);
      plan_row_type row;
      row = '{is_csr: 1'b0, addr: '0, wdata: '0, op: '{func: f, item: k},
              typed: 1'b1, want: '{ok: ok, count: cnt}};
      return row;
   endfunction

   function automatic plan_row_type plain_row(sst_pkg::func_type f, logic [KEY_W-1:0] k);
      plan_row_type row;
      row = check_row(f, k, 1'b0, '0);
      row.typed = 1'b0;
      return row;
   endfunction

   function automatic plan_row_type csr_row(logic [ADDR_BITS-1:0] a, logic [31:0] d);
      plan_row_type row;
      row = check_row(sst_pkg::FUNC_LOOKUP, '0, 1'b0, '0);
      row.is_csr = 1'b1;
      row.addr   = a;
      row.wdata  = d;
      return row;
   endfunction

   // offer one transfer and record its expected result once taken
   task automatic push_item(input sst_pkg::req_type r, input bit typed,
                            input sst_pkg::rsp_type want);
      sst_pkg::rsp_type p;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      p = set_apply(r);
      due_results.push_back(typed ? want : p);
   endtask

   // random gap on the input side, mostly short
   task automatic sender_gap();
      int n;
      int pick;
      pick = $urandom_range(99);
      if (quiet_phase || pick < 65) n = 0;
      else if (pick < 95) n = $urandom_range(1, 3);
      else n = $urandom_range(8, 30);
      if (n > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_data  <= '{func: sst_pkg::func_type'($urandom_range(3)), item: $urandom()};
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // drop valid and wait until every result has come back
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write, then read back the capacity
   task automatic program_capacity(input logic [ADDR_BITS-1:0] a, input logic [31:0] d);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= a;
      csr_pwdata  <= d;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (a == ADDR_CAPACITY) cap_reg = d[CAP_W-1:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_CAPACITY;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[CAP_W-1:0] !== cap_reg) begin
         $display("%0t: capacity readback mismatch, expected %0d actual %0d",
                  $time, cap_reg, csr_prdata[CAP_W-1:0]);
         fault_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // result side stall: random bursts plus one long hold-off
   initial begin
      rsp_stall  = 1'b0;
      stall_left = 0;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left == 0 && !quiet_phase && $urandom_range(99) < 25) begin
            stall_left = ($urandom_range(99) < 8) ? $urandom_range(12, 30)
                                                  : $urandom_range(1, 3);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            $display("%0t: unexpected result, expected none actual ok %0b count %0d",
                     $time, rsp_data.ok, rsp_data.count);
            fault_count++;
         end else begin
            head_result = due_results.pop_front();
            if (rsp_data.ok !== head_result.ok) begin
               $display("%0t: ok mismatch, expected %0b actual %0b",
                        $time, head_result.ok, rsp_data.ok);
               fault_count++;
            end
            if (rsp_data.count !== head_result.count) begin
               $display("%0t: count mismatch, expected %0d actual %0d",
                        $time, head_result.count, rsp_data.count);
               fault_count++;
            end
         end
      end
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin
      int               ph;
      int               n;
      int               pick;
      int               add_w;
      int               erase_w;
      sst_pkg::req_type r;
      plan_row_type     row;

      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      fault_count  = 0;
      quiet_phase  = 1'b0;
      hold_request = 1'b0;
      set_fill     = 0;
      cap_reg      = sst_pkg::CAP_RESET;

      // directed plan: empty set, key extremes, swap on erase, full and lowered capacity
      plan.push_back(check_row(sst_pkg::FUNC_LOOKUP, 32'h0000_0000, 1'b0, 5'd0));
      plan.push_back(check_row(sst_pkg::FUNC_ERASE,  32'hFFFF_FFFF, 1'b1, 5'd0));
      plan.push_back(check_row(sst_pkg::FUNC_ADD,    32'h0000_0000, 1'b1, 5'd1));
      plan.push_back(check_row(sst_pkg::FUNC_ADD,    32'hFFFF_FFFF, 1'b1, 5'd2));
      plan.push_back(check_row(sst_pkg::FUNC_ADD,    32'h0000_0000, 1'b1, 5'd2));
      plan.push_back(check_row(sst_pkg::FUNC_ADD,    32'h5555_5555, 1'b1, 5'd3));
      plan.push_back(check_row(sst_pkg::FUNC_ADD,    32'hAAAA_AAAA, 1'b1, 5'd4));
      plan.push_back(check_row(sst_pkg::FUNC_ERASE,  32'h0000_0000, 1'b1, 5'd3));
      plan.push_back(plain_row(sst_pkg::FUNC_LOOKUP, 32'hAAAA_AAAA));
      plan.push_back(plain_row(sst_pkg::FUNC_ERASE,  32'hAAAA_AAAA));
      plan.push_back(plain_row(sst_pkg::FUNC_ERASE,  32'h5555_5555));
      plan.push_back(plain_row(sst_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF));
      plan.push_back(check_row(sst_pkg::FUNC_CLEAR,  32'h1234_5678, 1'b1, 5'd0));
      plan.push_back(csr_row(ADDR_CAPACITY, 32'd2));
      plan.push_back(check_row(sst_pkg::FUNC_ADD,    32'h0000_0001, 1'b1, 5'd1));
      plan.push_back(check_row(sst_pkg::FUNC_ADD,    32'h0000_0002, 1'b1, 5'd2));
      plan.push_back(check_row(sst_pkg::FUNC_ADD,    32'h0000_0003, 1'b0, 5'd2));
      plan.push_back(check_row(sst_pkg::FUNC_ADD,    32'h0000_0002, 1'b1, 5'd2));
      plan.push_back(csr_row(ADDR_CAPACITY, 32'd1));
      plan.push_back(check_row(sst_pkg::FUNC_ADD,    32'h0000_0003, 1'b0, 5'd2));
      plan.push_back(plain_row(sst_pkg::FUNC_LOOKUP, 32'h0000_0001));
      plan.push_back(check_row(sst_pkg::FUNC_ERASE,  32'h0000_0001, 1'b1, 5'd1));
      plan.push_back(check_row(sst_pkg::FUNC_ADD,    32'h0000_0003, 1'b0, 5'd1));
      plan.push_back(csr_row(ADDR_CAPACITY, 32'hFFFF_FFE0));
      plan.push_back(check_row(sst_pkg::FUNC_CLEAR,  32'hFFFF_FFFF, 1'b1, 5'd0));
      plan.push_back(check_row(sst_pkg::FUNC_ADD,    32'h0000_0007, 1'b0, 5'd0));
      plan.push_back(csr_row(ADDR_UNUSED,   32'd5));
      plan.push_back(plain_row(sst_pkg::FUNC_ADD,    32'h0000_0007));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part
      foreach (plan[i]) begin
         row = plan[i];
         if (row.is_csr) begin
            settle();
            program_capacity(row.addr, row.wdata);
         end else begin
            push_item(row.op, row.typed, row.want);
            sender_gap();
         end
      end

      // random phases, one capacity setting each
      for (ph = 0; ph < PHASES; ph++) begin
         settle();
         quiet_phase = (ph % 3 == 2);
         if (ph == 4) hold_request = 1'b1;
         program_capacity(ADDR_CAPACITY,
                          {27'($urandom_range(0, (1 << 27) - 1)), cap_plan[ph]});
         add_w   = (ph % 2 == 0) ? 55 : 30;
         erase_w = (ph % 2 == 0) ? 15 : 40;
         key_pool[0] = '0;
         key_pool[1] = '1;
         for (n = 2; n < POOL_SIZE; n++) key_pool[n] = $urandom();
         for (n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(99);
            if (pick < 3) r.func = sst_pkg::FUNC_CLEAR;
            else if (pick < 3 + add_w) r.func = sst_pkg::FUNC_ADD;
            else if (pick < 3 + add_w + erase_w) r.func = sst_pkg::FUNC_ERASE;
            else r.func = sst_pkg::FUNC_LOOKUP;
            r.item = ($urandom_range(99) < 88) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                               : $urandom();
            push_item(r, 1'b0, '0);
            sender_gap();
         end
      end

      settle();
      if (fault_count == 0 && due_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: small_set_table.f
rtl/core/sst_pkg.sv
rtl/core/sst_cell.sv
rtl/core/small_set_table.sv
tb/tb.sv
